// ----- hdl/pba_pkg.sv -----
// Package for the page bitmap allocator: sizes, command codes, controller states.
// No dependencies; used by hdl/page_bitmap_allocator_unit.sv.
package pba_pkg;

  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned PAGE_BYTES = 4096;   // power of two

  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned USED_W     = 13;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = 5;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W     = $clog2(PAGE_COUNT);
  localparam int unsigned WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  // Free-word search tree: groups of eight words.
  localparam int unsigned GRP_SIZE   = 8;
  localparam int unsigned GRP_IDX_W  = 3;
  localparam int unsigned GRP_COUNT  = (WORD_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GRP_W      = (GRP_COUNT > 1) ? $clog2(GRP_COUNT) : 1;

  // Page number taken from an address, wide enough for any word index and
  // for a compare against PAGE_COUNT.
  localparam int unsigned PGA_W      = ADDR_W - PAGE_SHIFT;
  localparam int unsigned PGX_A      = (PGA_W > WORD_W + BIT_W) ? PGA_W : WORD_W + BIT_W;
  localparam int unsigned PGX_W      = (PGX_A > PAGE_W) ? PGX_A : PAGE_W;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } pba_cmd_e;

  typedef enum logic [1:0] {
    PBA_IDLE,
    PBA_GROUP,
    PBA_WORD,
    PBA_MODIFY
  } pba_state_e;

endpackage

// ----- hdl/page_bitmap_allocator_unit.sv -----
// Page bitmap allocator (first fit), one bit per page in a 32-bit-wide RAM.
// Alloc runs through the group, word and modify steps after accept; mark/free/nop go straight
// to modify. One request at a time: the next is taken only once the controller is back in idle.
// Reset (rst_ni low, async): all pages free via per-word valid bits, counter zero;
// no clearing pass, requests are taken from the first cycle after reset.
// Uses hdl/pba_pkg.sv and hdl/pba_ram.sv.
module page_bitmap_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [pba_pkg::ADDR_W-1:0] byte_address_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pba_pkg::ADDR_W-1:0] page_address_o,
  output logic                       no_free_page_o,
  output logic [pba_pkg::USED_W-1:0] used_pages_o
);

  localparam int unsigned WORD_BITS = pba_pkg::WORD_BITS;
  localparam int unsigned WORD_W    = pba_pkg::WORD_W;
  localparam int unsigned BIT_W     = pba_pkg::BIT_W;
  localparam int unsigned PGX_W     = pba_pkg::PGX_W;
  localparam int unsigned GRP_W     = pba_pkg::GRP_W;
  localparam int unsigned GRP_IDX_W = pba_pkg::GRP_IDX_W;
  localparam int unsigned ADDR_W    = pba_pkg::ADDR_W;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  pba_pkg::pba_state_e state_q, state_d;
  pba_pkg::pba_cmd_e   cmd_q;

  logic [WORD_W-1:0]    word_q;      // word being modified
  logic [BIT_W-1:0]     bit_q;       // bit for mark/free
  logic                 inrange_q;   // mark/free page below PAGE_COUNT
  logic                 nofree_q;    // alloc search found no non-full word

  // Per-word summaries, all in flops: row written since reset, row all ones.
  logic [pba_pkg::WORD_COUNT-1:0] row_vld_q;
  logic [pba_pkg::WORD_COUNT-1:0] full_q;
  logic                           rd_vld_q;

  // First level of the free-word search, registered.
  logic [pba_pkg::GRP_COUNT-1:0]  grp_has_q, grp_has_d;
  logic [GRP_IDX_W-1:0]           grp_idx_q [pba_pkg::GRP_COUNT];
  logic [GRP_IDX_W-1:0]           grp_idx_d [pba_pkg::GRP_COUNT];

  logic [pba_pkg::USED_W-1:0]     cnt_q;

  // Output register
  logic                           out_valid_q;
  logic [ADDR_W-1:0]              page_addr_q;
  logic                           no_free_q;

  // ---------------------------------------------------------------------------
  // Request decode: page and word of the address for mark/free
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic [PGX_W-1:0]  in_page;
  logic              in_inrange;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_page    = PGX_W'(byte_address_i >> pba_pkg::PAGE_SHIFT);
  assign in_inrange = {1'b0, in_page} < (PGX_W + 1)'(pba_pkg::PAGE_COUNT);

  // ---------------------------------------------------------------------------
  // Free-word search: group stage then group select
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int g = 0; g < int'(pba_pkg::GRP_COUNT); g++) begin
      grp_has_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int k = int'(pba_pkg::GRP_SIZE) - 1; k >= 0; k--) begin
        if ((g * int'(pba_pkg::GRP_SIZE) + k) < int'(pba_pkg::WORD_COUNT)) begin
          if (!full_q[g * int'(pba_pkg::GRP_SIZE) + k]) begin
            grp_has_d[g] = 1'b1;
            grp_idx_d[g] = GRP_IDX_W'(k);
          end
        end
      end
    end
  end

  logic                       sel_found;
  logic [GRP_W-1:0]           sel_grp;
  logic [WORD_W-1:0]          sel_word;

  always_comb begin
    sel_found = 1'b0;
    sel_grp   = '0;
    for (int g = int'(pba_pkg::GRP_COUNT) - 1; g >= 0; g--) begin
      if (grp_has_q[g]) begin
        sel_found = 1'b1;
        sel_grp   = GRP_W'(g);
      end
    end
  end

  assign sel_word = WORD_W'({sel_grp, grp_idx_q[sel_grp]});

  // ---------------------------------------------------------------------------
  // Read-modify-write of one bitmap word
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0]     ram_rdata;
  logic [WORD_BITS-1:0]     rd_word;     // unwritten rows read as all free
  logic [BIT_W-1:0]         free_bit;
  logic [BIT_W-1:0]         mod_bit;
  logic [WORD_BITS-1:0]     mod_mask;
  logic [WORD_BITS-1:0]     new_word;
  logic [WORD_W+BIT_W-1:0]  alloc_page;
  logic                     alloc_ok;
  logic                     set_bit;
  logic                     bit_was;
  logic                     do_write;
  logic                     mod_go;
  logic [ADDR_W+WORD_W+BIT_W-1:0] alloc_addr_wide;

  assign rd_word = rd_vld_q ? ram_rdata : '0;

  always_comb begin
    free_bit = '0;
    for (int b = int'(WORD_BITS) - 1; b >= 0; b--) begin
      if (!rd_word[b]) begin
        free_bit = BIT_W'(b);
      end
    end
  end

  assign alloc_page = {word_q, free_bit};
  assign alloc_ok   = !nofree_q &&
                      ({1'b0, alloc_page} < (WORD_W + BIT_W + 1)'(pba_pkg::PAGE_COUNT));
  assign mod_bit    = (cmd_q == pba_pkg::CMD_ALLOC) ? free_bit : bit_q;
  assign mod_mask   = WORD_BITS'(1) << mod_bit;
  assign set_bit    = (cmd_q != pba_pkg::CMD_FREE);
  assign bit_was    = |(rd_word & mod_mask);
  assign new_word   = set_bit ? (rd_word | mod_mask) : (rd_word & ~mod_mask);

  assign alloc_addr_wide = (ADDR_W + WORD_W + BIT_W)'(alloc_page) << pba_pkg::PAGE_SHIFT;

  // Result register free, or being drained this cycle.
  assign mod_go = (state_q == pba_pkg::PBA_MODIFY) && (!out_valid_q || !out_stall_i);

  always_comb begin
    do_write = 1'b0;
    case (cmd_q)
      pba_pkg::CMD_ALLOC: do_write = alloc_ok;
      pba_pkg::CMD_MARK,
      pba_pkg::CMD_FREE:  do_write = inrange_q && (bit_was != set_bit);
      default:            do_write = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      pba_pkg::PBA_IDLE: begin
        if (in_acc) begin
          state_d = (pba_pkg::pba_cmd_e'(cmd_i) == pba_pkg::CMD_ALLOC) ?
                    pba_pkg::PBA_GROUP : pba_pkg::PBA_MODIFY;
        end
      end
      pba_pkg::PBA_GROUP:  state_d = pba_pkg::PBA_WORD;
      pba_pkg::PBA_WORD:   state_d = pba_pkg::PBA_MODIFY;
      pba_pkg::PBA_MODIFY: begin
        if (mod_go) begin
          state_d = pba_pkg::PBA_IDLE;
        end
      end
      default:             state_d = pba_pkg::PBA_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller: outputs (RAM read port, request stall)
  // ---------------------------------------------------------------------------
  logic              ram_re;
  logic [WORD_W-1:0] ram_raddr;

  // In idle the stall is low, so a valid request is taken this cycle.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_raddr  = sel_word;
    case (state_q)
      pba_pkg::PBA_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_valid_i;
        ram_raddr  = in_page[WORD_W+BIT_W-1:BIT_W];
      end
      pba_pkg::PBA_WORD: begin
        ram_re     = sel_found;
        ram_raddr  = sel_word;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (pba_pkg::WORD_COUNT)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mod_go && do_write),
    .waddr_i (word_q),
    .wdata_i (new_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pba_pkg::PBA_IDLE;
      row_vld_q   <= '0;
      full_q      <= '0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      grp_has_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ram_re) begin
        rd_vld_q <= row_vld_q[ram_raddr];
      end
      if (state_q == pba_pkg::PBA_GROUP) begin
        grp_has_q <= grp_has_d;
      end
      if (mod_go && do_write) begin
        row_vld_q[word_q] <= 1'b1;
        full_q[word_q]    <= &new_word;
        cnt_q             <= set_bit ? cnt_q + 1'b1 : cnt_q - 1'b1;
      end
      if (mod_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q     <= pba_pkg::pba_cmd_e'(cmd_i);
      word_q    <= in_page[WORD_W+BIT_W-1:BIT_W];
      bit_q     <= in_page[BIT_W-1:0];
      inrange_q <= in_inrange;
      nofree_q  <= 1'b0;
    end
    if (state_q == pba_pkg::PBA_GROUP) begin
      grp_idx_q <= grp_idx_d;
    end
    if (state_q == pba_pkg::PBA_WORD) begin
      word_q   <= sel_word;
      nofree_q <= !sel_found;
    end
    if (mod_go) begin
      page_addr_q <= ((cmd_q == pba_pkg::CMD_ALLOC) && alloc_ok) ?
                     alloc_addr_wide[ADDR_W-1:0] : '0;
      no_free_q   <= (cmd_q == pba_pkg::CMD_ALLOC) && !alloc_ok;
    end
  end

  // used_pages reports the counter after the request; it only moves on mod_go,
  // and the result is taken before the next request can change it.
  assign out_valid_o    = out_valid_q;
  assign page_address_o = page_addr_q;
  assign no_free_page_o = no_free_q;
  assign used_pages_o   = cnt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_only_on_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mod_go && do_write) |=> $stable(cnt_q))
    else $error("used counter moved without a bitmap write");

  a_write_in_modify : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_go && do_write) |-> (state_q == pba_pkg::PBA_MODIFY))
    else $error("bitmap write outside the modify step");

  a_alloc_takes_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_go && (cmd_q == pba_pkg::CMD_ALLOC) && alloc_ok) |-> !bit_was)
    else $error("alloc picked a page already in use");

  a_result_from_modify : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == pba_pkg::PBA_MODIFY))
    else $error("result raised outside the modify step");

  a_idle_accepts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != pba_pkg::PBA_IDLE))
    else $error("accepted request left controller idle");

endmodule

// ----- hdl/pba_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for page_bitmap_allocator_unit: a directed table, then random,
// page reuse and drain traffic, checked against an in-bench bitmap allocator (typed rows against the table).
// Depends on hdl/pba_pkg.sv and hdl/page_bitmap_allocator_unit.sv.
module testbench;

  typedef struct packed {
    logic [pba_pkg::ADDR_W-1:0] page_address;
    logic                       no_free_page;
    logic [pba_pkg::USED_W-1:0] used_pages;
  } page_result_t;

  // One row of the directed table; result is only used when typed is set.
  typedef struct {
    pba_pkg::pba_cmd_e          cmd;
    logic [pba_pkg::ADDR_W-1:0] addr;
    bit                         typed;
    page_result_t               result;
  } directed_row_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 cmd_i          = pba_pkg::CMD_NOP;
  logic [pba_pkg::ADDR_W-1:0] byte_address_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic [pba_pkg::ADDR_W-1:0] page_address_o;
  logic                       no_free_page_o;
  logic [pba_pkg::USED_W-1:0] used_pages_o;

  // Shadow of the allocator: one bit per page, plus the used-page count.
  logic [pba_pkg::WORD_BITS-1:0] usage_words [pba_pkg::WORD_COUNT];
  int unsigned                   used_count;
  page_result_t                  pending_results [$];
  int unsigned                   fault_count;
  int unsigned                   burst_left;

  // Rows marked typed carry an answer that is obvious from the state after reset:
  // pages zero and one handed out, marks and frees that do and do not change a bit, unused command.
  directed_row_t directed_rows [22] = '{
    '{pba_pkg::CMD_ALLOC, 24'h000000, 1'b1, '{24'h000000, 1'b0, 13'd1}},
    '{pba_pkg::CMD_ALLOC, 24'hFFFFFF, 1'b1, '{24'h001000, 1'b0, 13'd2}},
    '{pba_pkg::CMD_MARK,  24'hFFFFFF, 1'b1, '{24'h000000, 1'b0, 13'd3}},
    '{pba_pkg::CMD_MARK,  24'hFFF000, 1'b1, '{24'h000000, 1'b0, 13'd3}},
    '{pba_pkg::CMD_FREE,  24'h000FFF, 1'b1, '{24'h000000, 1'b0, 13'd2}},
    '{pba_pkg::CMD_FREE,  24'h000000, 1'b1, '{24'h000000, 1'b0, 13'd2}},
    '{pba_pkg::CMD_ALLOC, 24'h555555, 1'b1, '{24'h000000, 1'b0, 13'd3}},
    '{pba_pkg::CMD_NOP,   24'hFFFFFF, 1'b1, '{24'h000000, 1'b0, 13'd3}},
    '{pba_pkg::CMD_NOP,   24'h000000, 1'b1, '{24'h000000, 1'b0, 13'd3}},
    '{pba_pkg::CMD_MARK,  24'hAAAAAA, 1'b0, '0},
    '{pba_pkg::CMD_MARK,  24'h555555, 1'b0, '0},
    '{pba_pkg::CMD_ALLOC, 24'h000000, 1'b0, '0},
    '{pba_pkg::CMD_MARK,  24'h003ABC, 1'b0, '0},
    '{pba_pkg::CMD_ALLOC, 24'hAAAAAA, 1'b0, '0},
    '{pba_pkg::CMD_FREE,  24'h001234, 1'b0, '0},
    '{pba_pkg::CMD_ALLOC, 24'h000000, 1'b0, '0},
    '{pba_pkg::CMD_MARK,  24'h01F000, 1'b0, '0},
    '{pba_pkg::CMD_MARK,  24'h020000, 1'b0, '0},
    '{pba_pkg::CMD_FREE,  24'hFFF123, 1'b0, '0},
    '{pba_pkg::CMD_FREE,  24'hAAAAAA, 1'b0, '0},
    '{pba_pkg::CMD_FREE,  24'h7FFFFF, 1'b0, '0},
    '{pba_pkg::CMD_ALLOC, 24'hFFFFFF, 1'b0, '0}
  };

  page_bitmap_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .byte_address_i (byte_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .page_address_o (page_address_o),
    .no_free_page_o (no_free_page_o),
    .used_pages_o   (used_pages_o)
  );

  always #2 clk_i = ~clk_i;

  // Lowest clear bit in the shadow map, PAGE_COUNT when every page is taken.
  function automatic int unsigned lowest_free_page();
    for (int unsigned w = 0; w < pba_pkg::WORD_COUNT; w++) begin
      if (~usage_words[w] != '0) begin
        for (int unsigned b = 0; b < pba_pkg::WORD_BITS; b++) begin
          if (!usage_words[w][b] && w * pba_pkg::WORD_BITS + b < pba_pkg::PAGE_COUNT)
            return w * pba_pkg::WORD_BITS + b;
        end
      end
    end
    return pba_pkg::PAGE_COUNT;
  endfunction

  // Applies one accepted request to the shadow map and returns what the block
  // should report for it.
  function automatic page_result_t apply_request(pba_pkg::pba_cmd_e c,
                                                 logic [pba_pkg::ADDR_W-1:0] a);
    page_result_t r;
    int unsigned  pg;
    bit           set_it;
    r      = '0;
    set_it = (c == pba_pkg::CMD_MARK);
    case (c)
      pba_pkg::CMD_ALLOC: begin
        pg = lowest_free_page();
        if (pg >= pba_pkg::PAGE_COUNT) begin
          r.no_free_page = 1'b1;      // full: nothing changes
        end else begin
          usage_words[pg / pba_pkg::WORD_BITS][pg % pba_pkg::WORD_BITS] = 1'b1;
          used_count++;
          r.page_address = pba_pkg::ADDR_W'(64'(pg) * pba_pkg::PAGE_BYTES);
        end
      end
      pba_pkg::CMD_MARK, pba_pkg::CMD_FREE: begin
        pg = a >> pba_pkg::PAGE_SHIFT;
        // pages past the end and bits already in the wanted state are left alone
        if (pg < pba_pkg::PAGE_COUNT &&
            usage_words[pg / pba_pkg::WORD_BITS][pg % pba_pkg::WORD_BITS] != set_it) begin
          usage_words[pg / pba_pkg::WORD_BITS][pg % pba_pkg::WORD_BITS] = set_it;
          if (set_it) used_count++;
          else used_count--;
        end
      end
      default: ;
    endcase
    r.used_pages = pba_pkg::USED_W'(used_count);
    return r;
  endfunction

  // Mostly an address in pages zero to top_page (low pages, where allocations land), sometimes
  // any 24-bit value so every address bit toggles.
  function automatic logic [pba_pkg::ADDR_W-1:0] pick_address(input int unsigned top_page);
    if ($urandom_range(0, 9) < 3) return pba_pkg::ADDR_W'($urandom);
    return pba_pkg::ADDR_W'(($urandom_range(0, top_page) << pba_pkg::PAGE_SHIFT)
                            | $urandom_range(0, pba_pkg::PAGE_BYTES - 1));
  endfunction

  // Drives one request and holds it until accepted; records the expected result at
  // the accepting edge. Requests go out in bursts, mostly with idle gaps between them.
  task automatic send_request(input pba_pkg::pba_cmd_e c,
                              input logic [pba_pkg::ADDR_W-1:0] a,
                              input bit typed, input page_result_t typed_result);
    page_result_t want;
    int unsigned  gap;
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    byte_address_i <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = apply_request(c, a);
    pending_results.push_back(typed ? typed_result : want);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic random_mix(input int unsigned count, input int unsigned alloc_pct,
                            input int unsigned mark_pct, input int unsigned free_pct,
                            input int unsigned top_page);
    int unsigned       roll;
    pba_pkg::pba_cmd_e c;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) c = pba_pkg::CMD_ALLOC;
      else if (roll < alloc_pct + mark_pct) c = pba_pkg::CMD_MARK;
      else if (roll < alloc_pct + mark_pct + free_pct) c = pba_pkg::CMD_FREE;
      else c = pba_pkg::CMD_NOP;
      send_request(c, pick_address(top_page), 1'b0, '0);
    end
  endtask

  // Result side: stall in segments, each with its own stall density (zero included).
  initial begin
    int unsigned seg;
    int unsigned pct;
    forever begin
      seg = $urandom_range(8, 64);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 30;
        2: pct = 60;
        default: pct = 90;
      endcase
      repeat (seg) begin
        @(posedge clk_i);
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Every accepted result must match the oldest outstanding expectation.
  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected result: page_address=%h no_free_page=%b used_pages=%0d",
                   page_address_o, no_free_page_o, used_pages_o);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.page_address !== page_address_o || want.no_free_page !== no_free_page_o
            || want.used_pages !== used_pages_o) begin
          if (fault_count < 10)
            $display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
                     want.page_address, want.no_free_page, want.used_pages,
                     page_address_o, no_free_page_o, used_pages_o);
          fault_count++;
        end
      end
    end
  end

  initial begin
    logic [pba_pkg::ADDR_W-1:0] addr;
    foreach (usage_words[w]) usage_words[w] = '0;
    used_count  = 0;
    fault_count = 0;
    burst_left  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].typed,
                   directed_rows[i].result);

    // churn on the low pages so frees hit allocated pages and holes get reused
    random_mix(350, 40, 20, 30, 127);

    // frees of the last page and of page zero, each followed by an alloc, then free/refill pairs
    send_request(pba_pkg::CMD_FREE, 24'hFFFABC, 1'b0, '0);
    send_request(pba_pkg::CMD_ALLOC, 24'h000000, 1'b0, '0);
    send_request(pba_pkg::CMD_FREE, 24'h000123, 1'b0, '0);
    send_request(pba_pkg::CMD_ALLOC, 24'hFFFFFF, 1'b0, '0);
    repeat (40) begin
      addr = pick_address(pba_pkg::PAGE_COUNT - 1);
      send_request(pba_pkg::CMD_FREE, addr, 1'b0, '0);
      if ($urandom_range(0, 1) != 0)
        send_request(pba_pkg::CMD_ALLOC, pba_pkg::ADDR_W'($urandom), 1'b0, '0);
      else send_request(pba_pkg::CMD_MARK, addr, 1'b0, '0);
      if ($urandom_range(0, 3) == 0)
        send_request(pba_pkg::CMD_ALLOC, pba_pkg::ADDR_W'($urandom), 1'b0, '0);
    end

    // drain across the whole range, free-heavy
    random_mix(240, 20, 10, 60, pba_pkg::PAGE_COUNT - 1);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

endmodule
